FILE: src/rgb_ycbcr_color_converter_core_macros.svh
// assertion macros shared by the color converter rtl
`ifndef RGB_YCBCR_COLOR_CONVERTER_CORE_MACROS_SVH
`define RGB_YCBCR_COLOR_CONVERTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RYCC_ASSERT_SAME(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rycc same-cycle check failed");
// next-cycle implication
`define RYCC_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rycc next-cycle check failed");
`else
`define RYCC_ASSERT_SAME(label, ck, rn, ante, cons)
`define RYCC_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

FILE: src/rycc_pkg.sv
// shared types, register indexes and elaboration-time coefficient math
package rycc_pkg;

    localparam int COEF_FRAC_BITS_DEF = 14;

    // coefficient scale: thousandths over 255
    localparam longint SCALE_DEN = 64'sd255000;

    // register indexes on the configuration port
    localparam logic [0:0] CFG_COLOR_STANDARD = 1'b0;
    localparam logic [0:0] CFG_DIRECTION      = 1'b1;

    // forward matrices in thousandths, bt.601 then bt.709
    localparam longint FWD_MILLI [2][3][3] = '{
        '{'{ 65481,  128553,  24966},
          '{-37797,  -74203, 112000},
          '{112000,  -93786, -18214}},
        '{'{ 46559,  156629,  15812},
          '{-25664,  -86336, 112000},
          '{112000, -101730, -10270}}
    };

    // pipeline advance enables for the three stages
    typedef struct packed {
        logic stage1_en;
        logic stage2_en;
        logic stage3_en;
    } rycc_adv_t;

    function automatic int wrap3(input int k);
        return (k >= 3) ? k - 3 : k;
    endfunction

    // round(num * 2^frac / den), ties away from zero, by long division
    function automatic longint fix_q(input longint num, input longint den, input int frac);
        logic        neg;
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? 64'(-num) : 64'(num);
        d   = (den < 0) ? 64'(-den) : 64'(den);
        q   = '0;
        r   = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        for (int i = 0; i < frac; i++) begin
            q = {q[62:0], 1'b0};
            r = {r[62:0], 1'b0};
            if (r >= d) begin
                r    = r - d;
                q[0] = 1'b1;
            end
        end
        r = {r[62:0], 1'b0};
        if (r >= d) begin
            q = q + 64'd1;
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // cofactor of the forward matrix (adjugate entry)
    function automatic longint milli_adj(input int std, input int i, input int j);
        int i1;
        int i2;
        int j1;
        int j2;
        i1 = wrap3(i + 1);
        i2 = wrap3(i + 2);
        j1 = wrap3(j + 1);
        j2 = wrap3(j + 2);
        return FWD_MILLI[std][j1][i1] * FWD_MILLI[std][j2][i2]
             - FWD_MILLI[std][j1][i2] * FWD_MILLI[std][j2][i1];
    endfunction

    function automatic longint milli_det(input int std);
        longint det;
        det = 0;
        for (int j = 0; j < 3; j++) begin
            det = det + FWD_MILLI[std][0][j] * milli_adj(std, j, 0);
        end
        return det;
    endfunction

    // matrix entry for direction dir and standard std
    function automatic longint coef_q(input int dir, input int std, input int row,
                                      input int col, input int frac);
        if (dir == 0) begin
            return fix_q(FWD_MILLI[std][row][col], SCALE_DEN, frac);
        end
        return fix_q(SCALE_DEN * milli_adj(std, row, col), milli_det(std), frac);
    endfunction

    // additive offset for one output row
    function automatic longint off_q(input int dir, input int std, input int row,
                                     input int frac);
        longint o;
        if (dir == 0) begin
            return (row == 0) ? (longint'(16) <<< frac) : (longint'(128) <<< frac);
        end
        o = 16 * milli_adj(std, row, 0) + 128 * milli_adj(std, row, 1)
          + 128 * milli_adj(std, row, 2);
        return fix_q(-(SCALE_DEN * o), milli_det(std), frac);
    endfunction

endpackage

FILE: src/rgb_ycbcr_color_converter_core.sv
// top level: rgb <-> limited-range ycbcr pixel converter, three-stage pipeline
//
//  channel | handshake               | word
//  --------+-------------------------+------------------------------------------
//  in      | in_valid / in_stall     | comp_in_first, comp_in_second, comp_in_third
//  out     | out_valid / out_stall   | comp_out_first, comp_out_second, comp_out_third
//  cfg     | cfg_write               | cfg_index, cfg_data
//
// one word per clock sustained while out is not stalled; the stages are multiply,
// sum and round/clamp; the stage count sets the latency; all nine products form
// at once in stage 1, so a new word can enter every clock while in_stall is low
// reset clears the valid bits and sets bt.601 forward conversion
// out_stall holds full stages past the last gap; gaps still fill, so bubbles collapse
// in_stall rises only when all three stages hold a word and out is stalled
module rgb_ycbcr_color_converter_core #(
    parameter int COEF_FRAC_BITS = rycc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [0:0] cfg_index,
    input  logic [0:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] comp_in_first,
    input  logic [7:0] comp_in_second,
    input  logic [7:0] comp_in_third,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] comp_out_first,
    output logic [7:0] comp_out_second,
    output logic [7:0] comp_out_third
);
    import rycc_pkg::*;
    `include "rgb_ycbcr_color_converter_core_macros.svh"

    localparam int CoefW = COEF_FRAC_BITS + 3;
    localparam int OffW  = COEF_FRAC_BITS + 11;

    // config registers
    logic color_standard_reg;
    logic direction_reg;

    // pipeline valid bits, one per stage
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;

    // coefficient set carried with the word: {direction, standard}
    logic [1:0] set_now;
    logic [1:0] set1_reg;

    rycc_adv_t adv;

    // constant tables, indexed by set, row, column
    logic signed [CoefW-1:0] coef_tab [4][3][3];
    logic signed [OffW-1:0]  off_tab [4][3];
    logic signed [CoefW-1:0] coef_sel [3][3];
    logic signed [OffW-1:0]  off_sel [3];
    logic [7:0]              comp_row [3];

    for (genvar d = 0; d < 2; d++) begin : g_dir
        for (genvar s = 0; s < 2; s++) begin : g_std
            for (genvar i = 0; i < 3; i++) begin : g_row
                localparam logic signed [OffW-1:0] OffK =
                    OffW'(off_q(d, s, i, COEF_FRAC_BITS));
                assign off_tab[2*d+s][i] = OffK;
                for (genvar j = 0; j < 3; j++) begin : g_col
                    localparam logic signed [CoefW-1:0] CoefK =
                        CoefW'(coef_q(d, s, i, j, COEF_FRAC_BITS));
                    assign coef_tab[2*d+s][i][j] = CoefK;
                end
            end
        end
    end

    // stage advance: a stage moves when it is empty or the next one moves
    assign adv.stage3_en = !out_valid_reg || !out_stall;
    assign adv.stage2_en = !s2_valid_reg || adv.stage3_en;
    assign adv.stage1_en = !s1_valid_reg || adv.stage2_en;
    assign in_stall      = !adv.stage1_en;

    assign set_now = {direction_reg, color_standard_reg};

    // coefficients chosen on entry, offsets from the set carried into stage 2
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                coef_sel[i][j] = coef_tab[set_now][i][j];
            end
            off_sel[i] = off_tab[set1_reg][i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            color_standard_reg <= 1'b0;
            direction_reg      <= 1'b0;
            s1_valid_reg       <= 1'b0;
            s2_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index)
                    CFG_COLOR_STANDARD: color_standard_reg <= cfg_data[0];
                    CFG_DIRECTION:      direction_reg      <= cfg_data[0];
                    default:            ;
                endcase
            end
            if (adv.stage1_en) begin
                s1_valid_reg <= in_valid;
            end
            if (adv.stage2_en) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv.stage3_en) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload side: no reset
    always_ff @(posedge clk)
    begin
        if (adv.stage1_en) begin
            set1_reg <= set_now;
        end
    end

    // one lane per output component
    for (genvar k = 0; k < 3; k++) begin : g_lane
        rycc_row #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_row (
            .clk  (clk),
            .adv  (adv),
            .x0   (comp_in_first),
            .x1   (comp_in_second),
            .x2   (comp_in_third),
            .coef (coef_sel[k]),
            .off  (off_sel[k]),
            .comp (comp_row[k])
        );
    end

    assign out_valid       = out_valid_reg;
    assign comp_out_first  = comp_row[0];
    assign comp_out_second = comp_row[1];
    assign comp_out_third  = comp_row[2];

    // an accepted word lands in stage 1
    `RYCC_ASSERT_NEXT(a_in_to_s1, clk, rst_n, in_valid && !in_stall, s1_valid_reg)
    // a word leaving stage 1 lands in stage 2
    `RYCC_ASSERT_NEXT(a_s1_to_s2, clk, rst_n, s1_valid_reg && adv.stage2_en, s2_valid_reg)
    // a word leaving stage 2 reaches the output register
    `RYCC_ASSERT_NEXT(a_s2_to_out, clk, rst_n, s2_valid_reg && adv.stage3_en, out_valid_reg)
    // a held stage 1 keeps its word
    `RYCC_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !adv.stage2_en, s1_valid_reg)
    // the input is stalled only with every stage full and out stalled
    `RYCC_ASSERT_SAME(a_full_stall, clk, rst_n, in_stall,
        s1_valid_reg && s2_valid_reg && out_valid_reg && out_stall)

endmodule

FILE: src/rycc_row.sv
// one output component: multiply, sum with offset, round and clamp
module rycc_row #(
    parameter int COEF_FRAC_BITS = rycc_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  rycc_pkg::rycc_adv_t                adv,
    input  logic [7:0]                         x0,
    input  logic [7:0]                         x1,
    input  logic [7:0]                         x2,
    input  logic signed [COEF_FRAC_BITS+2:0]   coef [3],
    input  logic signed [COEF_FRAC_BITS+10:0]  off,
    output logic [7:0]                         comp
);
    import rycc_pkg::*;

    localparam int CoefW = COEF_FRAC_BITS + 3;
    localparam int ProdW = CoefW + 9;
    localparam int AccW  = COEF_FRAC_BITS + 13;
    localparam int IntW  = AccW - COEF_FRAC_BITS;
    localparam logic signed [AccW-1:0] HALF = AccW'(1) <<< (COEF_FRAC_BITS - 1);

    logic signed [8:0]       xs [3];
    logic signed [ProdW-1:0] prod_next [3];
    logic signed [ProdW-1:0] prod_reg [3];
    logic signed [AccW-1:0]  acc_next;
    logic signed [AccW-1:0]  acc_reg;
    logic signed [AccW-1:0]  rnd;
    logic [IntW-1:0]         whole;
    logic [7:0]              comp_next;
    logic [7:0]              comp_reg;

    assign xs[0] = $signed({1'b0, x0});
    assign xs[1] = $signed({1'b0, x1});
    assign xs[2] = $signed({1'b0, x2});

    always_comb
    begin
        for (int k = 0; k < 3; k++) begin
            prod_next[k] = coef[k] * xs[k];
        end
    end

    assign acc_next = AccW'(prod_reg[0]) + AccW'(prod_reg[1]) + AccW'(prod_reg[2])
                    + AccW'(off);

    // round half up, clamp to 0..255
    assign rnd   = acc_reg + HALF;
    assign whole = rnd[AccW-1:COEF_FRAC_BITS];

    always_comb
    begin
        if (acc_reg[AccW-1] || (acc_reg == '0)) begin
            comp_next = 8'd0;
        end else if (|whole[IntW-1:8]) begin
            comp_next = 8'hFF;
        end else begin
            comp_next = whole[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.stage1_en) begin
            prod_reg <= prod_next;
        end
        if (adv.stage2_en) begin
            acc_reg <= acc_next;
        end
        if (adv.stage3_en) begin
            comp_reg <= comp_next;
        end
    end

    assign comp = comp_reg;

endmodule
